// ----- design/dlle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked list engine package
// Shared widths, codes, control word layout and the microcode table.
// ----------------------------------------------------------------------------
package dlle_pkg;

  localparam int unsigned NodeDepthDef = 1024;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned NodeW   = 10;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned UpcW    = 5;

  typedef logic [ModeW-1:0]   mode_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [UpcW-1:0]    upc_t;

  // Operation codes carried by the mode field.
  localparam mode_t ModePushFront = 3'd0;
  localparam mode_t ModePushBack  = 3'd1;
  localparam mode_t ModeInsBefore = 3'd2;
  localparam mode_t ModeInsAfter  = 3'd3;
  localparam mode_t ModeRemove    = 3'd4;
  localparam mode_t ModeFind      = 3'd5;

  // Result status codes.
  localparam status_t StOk   = 2'd0;
  localparam status_t StFull = 2'd1;
  localparam status_t StBad  = 2'd2;
  localparam status_t StMiss = 2'd3;

  // Microprogram addresses.
  localparam upc_t UpcIdle       = 5'd0;
  localparam upc_t UpcEndBad     = 5'd1;
  localparam upc_t UpcEndMiss    = 5'd2;
  localparam upc_t UpcPushFront  = 5'd3;
  localparam upc_t UpcPfFull     = 5'd4;
  localparam upc_t UpcPushBack   = 5'd5;
  localparam upc_t UpcPbFull     = 5'd6;
  localparam upc_t UpcIbRead     = 5'd7;
  localparam upc_t UpcIbCheck    = 5'd8;
  localparam upc_t UpcBadOrFull  = 5'd9;
  localparam upc_t UpcEndFull    = 5'd10;
  localparam upc_t UpcIaRead     = 5'd11;
  localparam upc_t UpcIaCheck    = 5'd12;
  localparam upc_t UpcIaError    = 5'd13;
  localparam upc_t UpcRmRead     = 5'd14;
  localparam upc_t UpcRmCheck    = 5'd15;
  localparam upc_t UpcRmWrite    = 5'd16;
  localparam upc_t UpcNewWrite   = 5'd17;
  localparam upc_t UpcNewLink    = 5'd18;
  localparam upc_t UpcFindInit   = 5'd19;
  localparam upc_t UpcFindTest   = 5'd20;
  localparam upc_t UpcFindCmp    = 5'd21;
  localparam upc_t UpcFindHit    = 5'd22;

  typedef enum logic [0:0] {
    RSEL_NODE = 1'b0,
    RSEL_CUR  = 1'b1
  } rsel_e;

  typedef enum logic [2:0] {
    AB_HOLD   = 3'd0,
    AB_FRONT  = 3'd1,
    AB_BACK   = 3'd2,
    AB_BEFORE = 3'd3,
    AB_AFTER  = 3'd4,
    AB_REMOVE = 3'd5
  } ab_e;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_NEW    = 2'd1,
    WR_LINK   = 2'd2,
    WR_UNLINK = 2'd3
  } wr_e;

  typedef enum logic [1:0] {
    CUR_HOLD  = 2'd0,
    CUR_FIRST = 2'd1,
    CUR_ADV   = 2'd2
  } cur_e;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NOTFULL  = 3'd2,
    C_GOOD     = 3'd3,
    C_BAD      = 3'd4,
    C_WALK_END = 3'd5,
    C_NOMATCH  = 3'd6
  } cond_e;

  typedef enum logic [2:0] {
    FIN_NONE    = 3'd0,
    FIN_OK_NEW  = 3'd1,
    FIN_OK_NODE = 3'd2,
    FIN_OK_CUR  = 3'd3,
    FIN_FULL    = 3'd4,
    FIN_BAD     = 3'd5,
    FIN_MISS    = 3'd6
  } fin_e;

  // One control word per microprogram step.
  typedef struct packed {
    rsel_e rsel;
    ab_e   ab;
    wr_e   wr;
    cur_e  cur;
    cond_e cond;
    upc_t  target;
    fin_e  fin;
  } uword_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic full;
    logic bad;
    logic walk_end;
    logic match;
  } flags_t;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '{rsel: RSEL_NODE, ab: AB_HOLD, wr: WR_NONE, cur: CUR_HOLD,
          cond: C_NEVER, target: UpcIdle, fin: FIN_NONE};
    case (pc)
      UpcIdle: ;
      UpcEndBad:  w.fin = FIN_BAD;
      UpcEndMiss: w.fin = FIN_MISS;
      UpcPushFront: begin
        w.ab     = AB_FRONT;
        w.cond   = C_NOTFULL;
        w.target = UpcNewWrite;
      end
      UpcPfFull: w.fin = FIN_FULL;
      UpcPushBack: begin
        w.ab     = AB_BACK;
        w.cond   = C_NOTFULL;
        w.target = UpcNewWrite;
      end
      UpcPbFull: w.fin = FIN_FULL;
      UpcIbRead: ;
      UpcIbCheck: begin
        w.ab     = AB_BEFORE;
        w.cond   = C_GOOD;
        w.target = UpcNewWrite;
      end
      UpcBadOrFull: begin
        w.cond   = C_BAD;
        w.target = UpcEndBad;
      end
      UpcEndFull: w.fin = FIN_FULL;
      UpcIaRead: ;
      UpcIaCheck: begin
        w.ab     = AB_AFTER;
        w.cond   = C_GOOD;
        w.target = UpcNewWrite;
      end
      UpcIaError: begin
        w.cond   = C_ALWAYS;
        w.target = UpcBadOrFull;
      end
      UpcRmRead: ;
      UpcRmCheck: begin
        w.ab     = AB_REMOVE;
        w.cond   = C_BAD;
        w.target = UpcEndBad;
      end
      UpcRmWrite: begin
        w.wr  = WR_UNLINK;
        w.fin = FIN_OK_NODE;
      end
      UpcNewWrite: w.wr = WR_NEW;
      UpcNewLink: begin
        w.wr  = WR_LINK;
        w.fin = FIN_OK_NEW;
      end
      UpcFindInit: w.cur = CUR_FIRST;
      UpcFindTest: begin
        w.rsel   = RSEL_CUR;
        w.cond   = C_WALK_END;
        w.target = UpcEndMiss;
      end
      UpcFindCmp: begin
        w.rsel   = RSEL_CUR;
        w.cur    = CUR_ADV;
        w.cond   = C_NOMATCH;
        w.target = UpcFindTest;
      end
      UpcFindHit: w.fin = FIN_OK_CUR;
      default: begin
        w.cond   = C_ALWAYS;
        w.target = UpcIdle;
      end
    endcase
    return w;
  endfunction

  // First microprogram step for each operation code.
  function automatic upc_t entry(input mode_t mode);
    upc_t pc;
    unique case (mode)
      ModePushFront: pc = UpcPushFront;
      ModePushBack:  pc = UpcPushBack;
      ModeInsBefore: pc = UpcIbRead;
      ModeInsAfter:  pc = UpcIaRead;
      ModeRemove:    pc = UpcRmRead;
      ModeFind:      pc = UpcFindInit;
      default:       pc = UpcEndBad;
    endcase
    return pc;
  endfunction

endpackage

// ----- design/dlle_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked list engine channels
// Valid/ready channel for operations and for results.
// ----------------------------------------------------------------------------
interface dlle_in_if;
  import dlle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ModeW-1:0]         mode;
  logic [NodeW-1:0]         node;
  logic signed [ValueW-1:0] value;

  modport source (output valid, mode, node, value, input ready);
  modport sink (input valid, mode, node, value, output ready);
endinterface

interface dlle_out_if;
  import dlle_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [NodeW-1:0]   result_node;

  modport source (output valid, status, result_node, input ready);
  modport sink (input valid, status, result_node, output ready);
endinterface

// ----- design/dlle_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked list engine sequencer
// Step counter, microcode lookup, dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module dlle_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  dlle_pkg::mode_t  mode_i,
  input  dlle_pkg::flags_t flags_i,
  input  logic             out_busy_i,
  output logic             in_ready_o,
  output dlle_pkg::uword_t uw_o,
  output logic             go_o
);
  import dlle_pkg::*;

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   cond_hit;

  assign uw         = ucode(upc_q);
  assign uw_o       = uw;
  assign in_ready_o = (upc_q == UpcIdle);
  // A finishing step waits until the result register is free.
  assign go_o       = !((uw.fin != FIN_NONE) && out_busy_i);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NOTFULL:  cond_hit = !flags_i.full;
      C_GOOD:     cond_hit = !flags_i.bad && !flags_i.full;
      C_BAD:      cond_hit = flags_i.bad;
      C_WALK_END: cond_hit = flags_i.walk_end;
      C_NOMATCH:  cond_hit = !flags_i.match;
      default:    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (upc_q == UpcIdle) begin
      if (in_valid_i) begin
        upc_d = entry(mode_i);
      end
    end else if (go_o) begin
      if (uw.fin != FIN_NONE) begin
        upc_d = UpcIdle;
      end else if (cond_hit) begin
        upc_d = uw.target;
      end else begin
        upc_d = upc_q + upc_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- design/dlle_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked list engine datapath
// Node memories, list registers, walk cursor and the result register.
// ----------------------------------------------------------------------------
module dlle_dpath #(
  parameter int unsigned NODE_DEPTH = dlle_pkg::NodeDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_accept_i,
  input  logic [dlle_pkg::NodeW-1:0]    node_i,
  input  logic signed [dlle_pkg::ValueW-1:0] value_i,
  input  dlle_pkg::uword_t              uw_i,
  input  logic                          go_i,
  input  logic                          out_ready_i,
  output dlle_pkg::flags_t              flags_o,
  output logic                          out_busy_o,
  output logic                          out_valid_o,
  output dlle_pkg::status_t             status_o,
  output logic [dlle_pkg::NodeW-1:0]    result_node_o
);
  import dlle_pkg::*;

  localparam int unsigned IdxW = $clog2(NODE_DEPTH);
  localparam int unsigned CmpW = ((IdxW > NodeW) ? IdxW : NodeW) + 1;
  localparam logic [CmpW-1:0] DepthC = CmpW'(NODE_DEPTH);

  typedef logic [IdxW-1:0] idx_t;

  // Node storage. Reads are not limited to allocated entries.
  logic [ValueW-1:0] val_mem  [NODE_DEPTH];
  idx_t              prev_mem [NODE_DEPTH];
  idx_t              next_mem [NODE_DEPTH];
  logic              dead_mem [NODE_DEPTH];

  logic [ValueW-1:0] val_rd_q;
  idx_t              prev_rd_q, next_rd_q;
  logic              dead_rd_q;

  logic [NodeW-1:0]  node_q;
  logic [ValueW-1:0] value_q;
  idx_t              a_q, b_q, cur_q;
  logic [IdxW:0]     steps_q;
  idx_t              first_q, last_q, alloc_q;

  idx_t              node_idx, new_idx, raddr, res_idx;
  logic [CmpW-1:0]   node_c, alloc_c, cur_c, steps_c, res_c;

  logic              val_we, prev_we, next_we, dead_we;
  idx_t              val_wa, prev_wa, next_wa, dead_wa;
  idx_t              prev_wd, next_wd;
  logic              dead_wd;

  logic              out_valid_q;
  status_t           status_q, status_d;
  logic [NodeW-1:0]  res_q;

  assign node_c   = CmpW'(node_q);
  assign node_idx = node_c[IdxW-1:0];
  assign alloc_c  = CmpW'(alloc_q);
  assign cur_c    = CmpW'(cur_q);
  assign steps_c  = CmpW'(steps_q);
  assign new_idx  = alloc_q + idx_t'(1);
  assign raddr    = (uw_i.rsel == RSEL_CUR) ? cur_q : node_idx;

  assign flags_o.full     = (alloc_c >= (DepthC - CmpW'(1)));
  assign flags_o.bad      = (node_c == '0) || (node_c >= DepthC) || (node_c > alloc_c) ||
                            dead_rd_q;
  assign flags_o.walk_end = (cur_c == '0) || (cur_c >= DepthC) || (steps_c >= DepthC);
  assign flags_o.match    = (val_rd_q == value_q);

  // Memory write ports, one per array.
  always_comb begin
    val_we  = 1'b0;
    val_wa  = new_idx;
    prev_we = 1'b0;
    prev_wa = new_idx;
    prev_wd = a_q;
    next_we = 1'b0;
    next_wa = new_idx;
    next_wd = b_q;
    dead_we = 1'b0;
    dead_wa = new_idx;
    dead_wd = 1'b0;
    if (go_i) begin
      case (uw_i.wr)
        WR_NEW: begin
          val_we  = 1'b1;
          prev_we = 1'b1;
          next_we = 1'b1;
          dead_we = 1'b1;
        end
        WR_LINK: begin
          next_we = (a_q != '0);
          next_wa = a_q;
          next_wd = new_idx;
          prev_we = (b_q != '0);
          prev_wa = b_q;
          prev_wd = new_idx;
        end
        WR_UNLINK: begin
          next_we = (a_q != '0);
          next_wa = a_q;
          next_wd = b_q;
          prev_we = (b_q != '0);
          prev_wa = b_q;
          prev_wd = a_q;
          dead_we = 1'b1;
          dead_wa = node_idx;
          dead_wd = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= value_q;
    end
    val_rd_q <= val_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd_q <= prev_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd_q <= next_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dead_we) begin
      dead_mem[dead_wa] <= dead_wd;
    end
    dead_rd_q <= dead_mem[raddr];
  end

  // Operation fields, neighbor pair and walk cursor.
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      node_q  <= node_i;
      value_q <= value_i;
    end
    if (go_i) begin
      case (uw_i.ab)
        AB_FRONT: begin
          a_q <= '0;
          b_q <= first_q;
        end
        AB_BACK: begin
          a_q <= last_q;
          b_q <= '0;
        end
        AB_BEFORE: begin
          a_q <= prev_rd_q;
          b_q <= node_idx;
        end
        AB_AFTER: begin
          a_q <= node_idx;
          b_q <= next_rd_q;
        end
        AB_REMOVE: begin
          a_q <= prev_rd_q;
          b_q <= next_rd_q;
        end
        default: ;
      endcase
      case (uw_i.cur)
        CUR_FIRST: begin
          cur_q   <= first_q;
          steps_q <= '0;
        end
        CUR_ADV: begin
          if (!flags_o.match) begin
            cur_q   <= next_rd_q;
            steps_q <= steps_q + (IdxW+1)'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Head, tail and bump allocator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '0;
      alloc_q <= '0;
    end else if (go_i) begin
      case (uw_i.wr)
        WR_LINK: begin
          if (a_q == '0) begin
            first_q <= new_idx;
          end
          if (b_q == '0) begin
            last_q <= new_idx;
          end
          alloc_q <= new_idx;
        end
        WR_UNLINK: begin
          if (a_q == '0) begin
            first_q <= b_q;
          end
          if (b_q == '0) begin
            last_q <= a_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_comb begin
    status_d = StOk;
    res_idx  = '0;
    case (uw_i.fin)
      FIN_OK_NEW:  res_idx = new_idx;
      FIN_OK_NODE: res_idx = node_idx;
      FIN_OK_CUR:  res_idx = cur_q;
      FIN_FULL:    status_d = StFull;
      FIN_BAD:     status_d = StBad;
      FIN_MISS:    status_d = StMiss;
      default: ;
    endcase
  end

  assign res_c = CmpW'(res_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go_i && (uw_i.fin != FIN_NONE)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && (uw_i.fin != FIN_NONE)) begin
      status_q <= status_d;
      res_q    <= res_c[NodeW-1:0];
    end
  end

  assign out_busy_o    = out_valid_q && !out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign result_node_o = res_q;

endmodule

// ----- design/doubly_linked_list_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked list engine
// Array-backed doubly linked list driven by a small microprogram.
// ----------------------------------------------------------------------------
// The engine keeps one doubly linked list of up to NODE_DEPTH-1 nodes and
// runs one operation per input transfer: push front, push back, insert
// before or after a live node, remove a live node, or find the first node
// from the head holding a value. Each operation yields exactly one result
// transfer with a status and a node index. Node indices are handed out by a
// bump counter starting at 1 and are never reused, so the store fills after
// NODE_DEPTH-1 inserts no matter how many nodes were removed. Operations run
// one at a time; a new operation is taken while the previous result still
// waits in the output register. Push front and push back check for room,
// write the new node and then link it; insert before and after first read
// the given node, check it, then write and link; remove reads, checks and
// unlinks; a find tests and compares each node it visits from the head.
// The steps come from the node memories, whose read data is registered,
// so every link read needs its own step before it can be used, and from
// the one write per memory per cycle that splits an insert into a node
// write and a neighbor update.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_top #(
  parameter int unsigned NODE_DEPTH = dlle_pkg::NodeDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  dlle_in_if.sink    in_i,
  dlle_out_if.source out_o
);
  import dlle_pkg::*;

  uword_t uw;
  flags_t flags;
  logic   go;
  logic   in_ready;
  logic   in_accept;
  logic   out_busy;

  // An operation transfer is taken only while the sequencer sits idle.
  assign in_i.ready = in_ready;
  assign in_accept  = in_i.valid && in_ready;

  // The sequencer steps through the microprogram; each control word picks
  // the memory read address, the neighbor pair to load, the memory writes
  // and whether the step finishes the operation.
  dlle_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .mode_i     (in_i.mode),
    .flags_i    (flags),
    .out_busy_i (out_busy),
    .in_ready_o (in_ready),
    .uw_o       (uw),
    .go_o       (go)
  );

  // The datapath holds the node memories, head, tail, allocator, the find
  // cursor and the result register that decouples the two channels.
  dlle_dpath #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .node_i        (in_i.node),
    .value_i       (in_i.value),
    .uw_i          (uw),
    .go_i          (go),
    .out_ready_i   (out_o.ready),
    .flags_o       (flags),
    .out_busy_o    (out_busy),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .result_node_o (out_o.result_node)
  );

endmodule

// ----- design/dlle_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doubly linked list engine checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module dlle_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input dlle_pkg::status_t          status_i,
  input logic [dlle_pkg::NodeW-1:0] result_node_i
);
  import dlle_pkg::*;

  logic [1:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Operations taken whose result has not been transferred yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(result_node_i))
    else $error("result payload changed while stalled");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != StOk) |-> (result_node_i == '0))
    else $error("failed operation reports a node");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("result without a pending operation");

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (pend_q == 2'd0) || (pend_q == 2'd1))
    else $error("operation taken while another is still in work");

endmodule

bind doubly_linked_list_engine_top dlle_check u_dlle_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .result_node_i (out_o.result_node)
);
